/* hw/rtl/wbps_pkg.sv */
// package for the wildcard byte pattern scanner: shared types and constants
`timescale 1ns / 1ps
`default_nettype none

package wbps_pkg;

  // default sizes
  localparam int MaxPatternDef = 64;
  localparam int CountBitsDef  = 32;

  // fixed field widths
  localparam int LenCfgW  = 7;
  localparam int EntryIdxW = 6;
  localparam int ByteW    = 8;
  localparam int OutW     = 32;

  // operation codes of an input item
  localparam logic OP_PATTERN = 1'b0;
  localparam logic OP_DATA    = 1'b1;

  // report codes
  typedef enum logic [1:0] {
    STATUS_SUCCESS   = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_MULTIPLE  = 2'd2,
    STATUS_INVALID   = 2'd3
  } status_e;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE    = 2'd0,
    S_COMPARE = 2'd1,
    S_COUNT   = 2'd2
  } ctl_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic pat_wr;
    logic shift;
    logic cmp_load;
    logic count;
    logic report;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic last;
  } dp_stat_t;

endpackage : wbps_pkg

`default_nettype wire

/* hw/rtl/wildcard_byte_pattern_scanner.sv */
// top level of the wildcard byte pattern scanner: controller plus datapath
// pattern write: taken in idle, and the next item can follow in the next cycle
// data byte: take and shift, registered compare of the aligned window, count update
// the next item waits for the count step, which a stalled result holds for the last byte
// a report is registered and shown in the cycle after the count step of the last byte
// async reset clears length, window and counters; pattern entries are undefined until written
`timescale 1ns / 1ps
`default_nettype none

module wildcard_byte_pattern_scanner
  import wbps_pkg::*;
#(
  parameter int MAX_PATTERN = MaxPatternDef,
  parameter int COUNT_BITS  = CountBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration write
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [LenCfgW-1:0]   cfg_data_i,
  // input items
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 operation_i,
  input  wire logic [EntryIdxW-1:0] entry_index_i,
  input  wire logic [ByteW-1:0]     entry_value_i,
  input  wire logic                 entry_wildcard_i,
  input  wire logic [ByteW-1:0]     data_byte_i,
  input  wire logic                 last_byte_i,
  // result items
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [1:0]                status_o,
  output logic [OutW-1:0]           match_offset_o,
  output logic [OutW-1:0]           match_count_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // the length register takes a write at any time
  assign cfg_ready_o = 1'b1;

  wbps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  wbps_dp #(
    .MAX_PATTERN (MAX_PATTERN),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .entry_index_i    (entry_index_i),
    .entry_value_i    (entry_value_i),
    .entry_wildcard_i (entry_wildcard_i),
    .data_byte_i      (data_byte_i),
    .last_byte_i      (last_byte_i),
    .status_o         (status_o),
    .match_offset_o   (match_offset_o),
    .match_count_o    (match_count_o)
  );

endmodule : wildcard_byte_pattern_scanner

`default_nettype wire

/* hw/rtl/wbps_ctrl.sv */
// controller state machine: sequences pattern writes and the per-byte scan steps
`timescale 1ns / 1ps
`default_nettype none

module wbps_ctrl
  import wbps_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire logic     operation_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  ctl_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_take;
  logic       out_free;

  // state and result-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_take  = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_take) begin
          if (operation_i == OP_PATTERN) begin
            cmd_o.pat_wr = 1'b1;
          end else begin
            cmd_o.shift = 1'b1;
            state_d     = S_COMPARE;
          end
        end
      end
      S_COMPARE: begin
        cmd_o.cmp_load = 1'b1;
        state_d        = S_COUNT;
      end
      S_COUNT: begin
        if (!stat_i.last) begin
          cmd_o.count = 1'b1;
          state_d     = S_IDLE;
        end else if (out_free) begin
          // hold the report until the result register is free
          cmd_o.count  = 1'b1;
          cmd_o.report = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule : wbps_ctrl

`default_nettype wire

/* hw/rtl/wbps_dp.sv */
// datapath: pattern store, byte window, aligned compare, counters and result register
`timescale 1ns / 1ps
`default_nettype none

module wbps_dp
  import wbps_pkg::*;
#(
  parameter int MAX_PATTERN = MaxPatternDef,
  parameter int COUNT_BITS  = CountBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire dp_cmd_t              cmd_i,
  output dp_stat_t                  stat_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [LenCfgW-1:0]   cfg_data_i,
  input  wire logic [EntryIdxW-1:0] entry_index_i,
  input  wire logic [ByteW-1:0]     entry_value_i,
  input  wire logic                 entry_wildcard_i,
  input  wire logic [ByteW-1:0]     data_byte_i,
  input  wire logic                 last_byte_i,
  output logic [1:0]                status_o,
  output logic [OutW-1:0]           match_offset_o,
  output logic [OutW-1:0]           match_count_o
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int CW    = (LEN_W > LenCfgW) ? LEN_W : LenCfgW;
  localparam int IW    = (LEN_W > EntryIdxW) ? LEN_W : EntryIdxW;
  localparam int CMPW  = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;
  localparam int OXW   = (COUNT_BITS > OutW) ? COUNT_BITS : OutW;
  localparam int WIN_BITS = MAX_PATTERN * ByteW;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [LenCfgW-1:0]    len_cfg_q;
  logic [ByteW-1:0]      pat_val_q  [MAX_PATTERN];
  logic                  pat_wild_q [MAX_PATTERN];
  logic [ByteW-1:0]      window_q   [MAX_PATTERN];
  logic [COUNT_BITS-1:0] bytes_seen_q;
  logic [COUNT_BITS-1:0] pos_q;
  logic [COUNT_BITS-1:0] matches_q;
  logic [COUNT_BITS-1:0] last_start_q;
  logic                  last_q;
  logic [MAX_PATTERN-1:0] cmp_q, cmp_d;
  logic [1:0]            status_q, status_d;
  logic [OutW-1:0]       offset_q, offset_d;
  logic [OutW-1:0]       count_q, count_d;

  logic [LEN_W-1:0]      act_len;
  logic [LEN_W-1:0]      sh_amt;
  logic [WIN_BITS-1:0]   aligned;
  logic [IW-1:0]         idx_ext;
  logic                  idx_ok;
  logic                  match;
  logic [COUNT_BITS-1:0] matches_new;
  logic [COUNT_BITS-1:0] start_new;
  logic [COUNT_BITS-1:0] match_start;

  // active length saturates at the store depth
  always_comb begin
    if (CW'(len_cfg_q) > CW'(MAX_PATTERN)) begin
      act_len = LEN_W'(MAX_PATTERN);
    end else begin
      act_len = LEN_W'(len_cfg_q);
    end
  end

  // length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_cfg_q <= '0;
    end else if (cfg_we_i) begin
      len_cfg_q <= cfg_data_i;
    end
  end

  // pattern entries, writes beyond the store depth are dropped
  assign idx_ext = IW'(entry_index_i);
  assign idx_ok  = idx_ext < IW'(MAX_PATTERN);

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      if (cmd_i.pat_wr && idx_ok && (idx_ext == IW'(j))) begin
        pat_val_q[j]  <= entry_value_i;
        pat_wild_q[j] <= entry_wildcard_i;
      end
    end
  end

  // align the window so lane j holds the byte compared with pattern entry j
  always_comb begin
    aligned = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      aligned[k*ByteW +: ByteW] = window_q[MAX_PATTERN-1-k];
    end
    sh_amt = LEN_W'(MAX_PATTERN) - act_len;
    for (int s = 0; s < LEN_W; s++) begin
      if (sh_amt[s]) begin
        aligned = aligned >> (ByteW * (1 << s));
      end
    end
  end

  // per-position compare, positions beyond the length always pass
  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      cmp_d[j] = (LEN_W'(j) >= act_len) || pat_wild_q[j] ||
                 (pat_val_q[j] == aligned[j*ByteW +: ByteW]);
    end
  end

  // match decision and counter updates
  always_comb begin
    match = (act_len != '0) && (&cmp_q) &&
            (CMPW'(bytes_seen_q) >= CMPW'(act_len));
    if (pos_q == COUNT_MAX) begin
      match_start = COUNT_MAX;
    end else begin
      match_start = COUNT_BITS'(CMPW'(pos_q) - CMPW'(act_len) + CMPW'(1));
    end
    matches_new = matches_q;
    start_new   = last_start_q;
    if (match) begin
      start_new = match_start;
      if (matches_q != COUNT_MAX) begin
        matches_new = matches_q + COUNT_BITS'(1);
      end
    end
  end

  // report contents
  always_comb begin
    status_d = status_q;
    offset_d = offset_q;
    count_d  = count_q;
    if (cmd_i.report) begin
      if (act_len == '0) begin
        status_d = STATUS_INVALID;
        offset_d = '0;
        count_d  = '0;
      end else begin
        if (matches_new == '0) begin
          status_d = STATUS_NOT_FOUND;
        end else if (matches_new == COUNT_BITS'(1)) begin
          status_d = STATUS_SUCCESS;
        end else begin
          status_d = STATUS_MULTIPLE;
        end
        offset_d = OutW'(OXW'(start_new));
        count_d  = OutW'(OXW'(matches_new));
      end
    end
  end

  // scan state: window, byte count and match record
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        window_q[k] <= '0;
      end
      bytes_seen_q <= '0;
      matches_q    <= '0;
      last_start_q <= '0;
    end else if (cmd_i.report) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        window_q[k] <= '0;
      end
      bytes_seen_q <= '0;
      matches_q    <= '0;
      last_start_q <= '0;
    end else begin
      if (cmd_i.shift) begin
        window_q[0] <= data_byte_i;
        for (int k = 1; k < MAX_PATTERN; k++) begin
          window_q[k] <= window_q[k-1];
        end
        if (bytes_seen_q != COUNT_MAX) begin
          bytes_seen_q <= bytes_seen_q + COUNT_BITS'(1);
        end
      end
      if (cmd_i.count) begin
        matches_q    <= matches_new;
        last_start_q <= start_new;
      end
    end
  end

  // per-item payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      pos_q  <= bytes_seen_q;
      last_q <= last_byte_i;
    end
    if (cmd_i.cmp_load) begin
      cmp_q <= cmp_d;
    end
    status_q <= status_d;
    offset_q <= offset_d;
    count_q  <= count_d;
  end

  assign stat_o.last    = last_q;
  assign status_o       = status_q;
  assign match_offset_o = offset_q;
  assign match_count_o  = count_q;

endmodule : wbps_dp

`default_nettype wire
